### sv/button_trigger_event_fsm_assert.svh
// Assertion macros used by the port-level checker file.
`ifndef BUTTON_TRIGGER_EVENT_FSM_ASSERT_SVH
`define BUTTON_TRIGGER_EVENT_FSM_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BTEV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("button trigger assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BTEV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("button trigger assertion failed");

`endif

### sv/btev_pkg.sv
// Package: constants, codes and types of the button trigger event detector.
`timescale 1ns / 1ps

package btev_pkg;

    localparam int NUM_BUTTONS = 7;
    localparam int LEVEL_W     = 7;
    localparam int DATA_W      = 8;
    localparam int TIME_W      = 16;
    localparam int MODE_W      = 2;
    localparam int CFG_W       = MODE_W + TIME_W;
    localparam int CFG_IDX_W   = 3;

    // Item kinds carried on tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_HOLD_WAIT  = 3'd1,
        PH_HOLD_FIRED = 3'd2,
        PH_REL_WAIT   = 3'd3,
        PH_REL_READY  = 3'd4
    } t_phase;

    typedef enum logic [MODE_W-1:0] {
        MODE_UNKNOWN = 2'd0,
        MODE_CHANGE  = 2'd1,
        MODE_HOLD    = 2'd2,
        MODE_RELEASE = 2'd3
    } t_mode;

    // One accepted item as seen by a single button
    typedef struct packed {
        logic acc;
        logic tick;
        logic chg;
        logic pressed;
    } t_cell_item;

    // Register write aimed at a single button
    typedef struct packed {
        logic              we;
        t_mode             mode;
        logic [TIME_W-1:0] ms;
    } t_cell_cfg;

endpackage

### sv/btev_cell.sv
// Per-button trigger state machine, countdown and trigger register.
`timescale 1ns / 1ps

module btev_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  btev_pkg::t_cell_cfg  i_cfg,
    input  btev_pkg::t_cell_item i_item,
    output logic                o_fired
);
    import btev_pkg::*;

    t_mode             r_mode;
    logic [TIME_W-1:0] r_time;
    t_phase            r_phase, n_phase;
    logic [TIME_W-1:0] r_count, n_count;

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        if (i_item.tick) begin
            if (r_phase == PH_HOLD_WAIT || r_phase == PH_REL_WAIT) begin
                if (r_count > TIME_W'(1)) begin
                    n_count = r_count - TIME_W'(1);
                end else begin
                    n_count = '0;
                    n_phase = (r_phase == PH_HOLD_WAIT) ? PH_HOLD_FIRED : PH_REL_READY;
                end
            end
        end else if (i_item.chg) begin
            unique case (r_mode)
                MODE_CHANGE: begin
                end
                MODE_HOLD: begin
                    if (!i_item.pressed) begin
                        n_phase = PH_IDLE;
                        n_count = '0;
                    end else if (r_phase == PH_IDLE) begin
                        n_phase = (r_time == '0) ? PH_HOLD_FIRED : PH_HOLD_WAIT;
                        n_count = r_time;
                    end
                end
                MODE_RELEASE: begin
                    if (i_item.pressed) begin
                        if (r_phase == PH_IDLE) begin
                            n_phase = (r_time == '0) ? PH_REL_READY : PH_REL_WAIT;
                            n_count = r_time;
                        end
                    end else if (r_phase == PH_REL_WAIT) begin
                        n_phase = PH_IDLE;
                        n_count = '0;
                    end else if (r_phase == PH_REL_READY) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_count = '0;
                end
            endcase
        end
    end

    // Event output
    always_comb begin
        o_fired = 1'b0;
        if (i_item.tick) begin
            o_fired = (r_phase == PH_HOLD_WAIT) && (r_count <= TIME_W'(1));
        end else if (i_item.chg) begin
            unique case (r_mode)
                MODE_CHANGE:  o_fired = 1'b1;
                MODE_HOLD:    o_fired = i_item.pressed && (r_phase == PH_IDLE)
                                        && (r_time == '0);
                MODE_RELEASE: o_fired = !i_item.pressed && (r_phase == PH_REL_READY);
                default:      o_fired = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_UNKNOWN;
            r_time  <= '0;
            r_phase <= PH_IDLE;
            r_count <= '0;
        end else if (i_cfg.we) begin
            // a mode change drops any running wait
            if (i_cfg.mode != r_mode) begin
                r_phase <= PH_IDLE;
                r_count <= '0;
            end
            r_mode <= i_cfg.mode;
            r_time <= i_cfg.ms;
        end else if (i_item.acc) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

endmodule

### sv/button_trigger_event_fsm.sv
// Top level of the button trigger event detector.
//
//  channel  | direction | handshake                        | payload
//  ---------+-----------+----------------------------------+------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready    | tdata: levels; tuser: op
//  m_axis   | out       | m_axis_tvalid / m_axis_tready    | tdata: fired
//  cfg      | in        | i_cfg_valid / o_cfg_ready        | i_cfg_index, i_cfg_data
//
//  One item per clock unless the output stalls; each transfer updates every cell
//  not taking a register write, and its mask lands in the output register.
//  The output register is the only stage; s_axis_tready drops only while a
//  result is held and the downstream stalls. The config channel is always ready.
//  Reset (synchronous, active low) clears levels, phases, countdowns and
//  trigger registers; no clearing pass is needed.
`timescale 1ns / 1ps

module button_trigger_event_fsm (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [btev_pkg::DATA_W-1:0]      s_axis_tdata,  // [6:0] levels, [7] zero
    input  logic                            s_axis_tuser,  // [0] op
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [btev_pkg::DATA_W-1:0]      m_axis_tdata,  // [6:0] fired, [7] zero
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [btev_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [btev_pkg::CFG_W-1:0]       i_cfg_data
);
    import btev_pkg::*;

    logic                   r_out_valid;
    logic [LEVEL_W-1:0]     r_fired;
    logic [LEVEL_W-1:0]     r_last;
    logic [LEVEL_W-1:0]     w_levels;
    logic [LEVEL_W-1:0]     w_changed;
    logic [LEVEL_W-1:0]     w_fired;
    logic [NUM_BUTTONS-1:0] w_cell_fired;
    logic                   w_acc;
    logic                   w_tick;

    // Accept whenever the output register is free or being emptied
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_tick        = s_axis_tuser;
    assign w_levels      = s_axis_tdata[LEVEL_W-1:0];
    assign w_changed     = r_last ^ w_levels;
    assign o_cfg_ready   = 1'b1;

    // One cell per button; unused mask bits stay low
    always_comb begin
        w_fired = '0;
        for (int k = 0; k < LEVEL_W; k++) begin
            if (k < NUM_BUTTONS) begin
                w_fired[k] = w_cell_fired[k];
            end
        end
    end

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_cell
        t_cell_cfg  w_cfg;
        t_cell_item w_item;

        always_comb begin
            w_cfg.we        = i_cfg_valid && (i_cfg_index == CFG_IDX_W'(g));
            w_cfg.mode      = t_mode'(i_cfg_data[CFG_W-1:TIME_W]);
            w_cfg.ms        = i_cfg_data[TIME_W-1:0];
            w_item.acc      = w_acc;
            w_item.tick     = w_tick;
            w_item.chg      = !w_tick && w_changed[g];
            w_item.pressed  = w_levels[g];
        end

        btev_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (w_cfg),
            .i_item  (w_item),
            .o_fired (w_cell_fired[g])
        );
    end

    // Hold the previous sample; ticks leave it alone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (w_acc && !w_tick) begin
            r_last <= w_levels;
        end
    end

    // Output register: load on transfer in, drop once taken downstream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_fired <= w_fired;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(DATA_W-LEVEL_W){1'b0}}, r_fired};

endmodule

### sv/btev_checker.sv
// Port-level checker for the button trigger event detector, with its bind.
`timescale 1ns / 1ps
`include "button_trigger_event_fsm_assert.svh"

module btev_port_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [btev_pkg::DATA_W-1:0]      m_axis_tdata
);
    import btev_pkg::*;

    logic w_in_xfer;
    logic w_out_stall;

    assign w_in_xfer   = s_axis_tvalid && s_axis_tready;
    assign w_out_stall = m_axis_tvalid && !m_axis_tready;

    // a stalled result stays valid
    `BTEV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, m_axis_tvalid)
    // and keeps its data
    `BTEV_ASSERT_NEXT(a_data_hold, i_clk, i_rst_n, w_out_stall, $stable(m_axis_tdata))
    // every transfer in yields a result next cycle
    `BTEV_ASSERT_NEXT(a_in_to_out, i_clk, i_rst_n, w_in_xfer, m_axis_tvalid)
    // no transfer in while a result waits on a stalled output
    `BTEV_ASSERT_NOW(a_full_stall, i_clk, i_rst_n, w_out_stall, !s_axis_tready)
    // padding bit of the result stays low
    `BTEV_ASSERT_NOW(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, !m_axis_tdata[DATA_W-1])

endmodule

bind button_trigger_event_fsm btev_port_checker u_btev_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### verif/btev_checker.sv
// Checker: watches the detector's channels, predicts each fired mask and compares it.
`timescale 1ns / 1ps

module btev_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream as seen at the block
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [btev_pkg::DATA_W-1:0]    i_in_data,   // [6:0] levels, [7] zero
    input  logic                           i_in_user,   // [0] op
    // result stream as seen at the block
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [btev_pkg::DATA_W-1:0]    i_out_data,  // [6:0] fired, [7] zero
    // register writes as seen at the block
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [btev_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [btev_pkg::CFG_W-1:0]     i_cfg_data,
    // end of test: count what is still outstanding
    input  logic                           i_eot,
    output int                             o_outstanding,
    output int                             o_fail_count
);
    import btev_pkg::*;

    // Trigger registers and per-button state of the prediction
    t_mode                btn_mode  [NUM_BUTTONS];
    logic [TIME_W-1:0]    btn_ms    [NUM_BUTTONS];
    t_phase               btn_phase [NUM_BUTTONS];
    logic [TIME_W-1:0]    btn_count [NUM_BUTTONS];
    logic [LEVEL_W-1:0]   prev_levels;

    logic [LEVEL_W-1:0]   fired_due [$];
    int                   mismatch_total = 0;
    logic                 eot_seen = 1'b0;

    function automatic void clear_state();
        prev_levels = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            btn_mode[b]  = MODE_UNKNOWN;
            btn_ms[b]    = '0;
            btn_phase[b] = PH_IDLE;
            btn_count[b] = '0;
        end
    endfunction

    function automatic void apply_trigger_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        t_mode m;
        m = t_mode'(val[CFG_W-1:TIME_W]);
        if (idx < NUM_BUTTONS) begin
            // a new mode drops any wait in progress; a new time alone does not
            if (m != btn_mode[idx]) begin
                btn_phase[idx] = PH_IDLE;
                btn_count[idx] = '0;
            end
            btn_mode[idx] = m;
            btn_ms[idx]   = val[TIME_W-1:0];
        end
    endfunction

    function automatic logic on_level_edge(int b, logic pressed);
        case (btn_mode[b])
            MODE_CHANGE: begin
                return 1'b1;
            end
            MODE_HOLD: begin
                if (!pressed) begin
                    btn_phase[b] = PH_IDLE;
                    btn_count[b] = '0;
                    return 1'b0;
                end
                if (btn_phase[b] != PH_IDLE) return 1'b0;
                if (btn_ms[b] == '0) begin
                    btn_phase[b] = PH_HOLD_FIRED;
                    btn_count[b] = '0;
                    return 1'b1;
                end
                btn_count[b] = btn_ms[b];
                btn_phase[b] = PH_HOLD_WAIT;
                return 1'b0;
            end
            MODE_RELEASE: begin
                if (pressed) begin
                    if (btn_phase[b] != PH_IDLE) return 1'b0;
                    if (btn_ms[b] == '0) begin
                        btn_phase[b] = PH_REL_READY;
                        btn_count[b] = '0;
                    end else begin
                        btn_count[b] = btn_ms[b];
                        btn_phase[b] = PH_REL_WAIT;
                    end
                    return 1'b0;
                end
                if (btn_phase[b] == PH_REL_WAIT) begin
                    btn_phase[b] = PH_IDLE;
                    btn_count[b] = '0;
                end else if (btn_phase[b] == PH_REL_READY) begin
                    btn_phase[b] = PH_IDLE;
                    return 1'b1;
                end
                return 1'b0;
            end
            default: begin
                btn_phase[b] = PH_IDLE;
                btn_count[b] = '0;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic logic on_ms_tick(int b);
        if (btn_phase[b] != PH_HOLD_WAIT && btn_phase[b] != PH_REL_WAIT) return 1'b0;
        if (btn_count[b] > 1) begin
            btn_count[b] = btn_count[b] - 1'b1;
            return 1'b0;
        end
        btn_count[b] = '0;
        if (btn_phase[b] == PH_HOLD_WAIT) begin
            btn_phase[b] = PH_HOLD_FIRED;
            return 1'b1;
        end
        btn_phase[b] = PH_REL_READY;
        return 1'b0;
    endfunction

    function automatic logic [LEVEL_W-1:0] predict_fired(logic op, logic [LEVEL_W-1:0] lv);
        logic [LEVEL_W-1:0] mask;
        logic [LEVEL_W-1:0] moved;
        mask = '0;
        if (op == OP_SAMPLE) begin
            moved = prev_levels ^ lv;
            for (int b = 0; b < NUM_BUTTONS; b++)
                if (moved[b]) mask[b] = on_level_edge(b, lv[b]);
            prev_levels = lv;
        end else begin
            for (int b = 0; b < NUM_BUTTONS; b++)
                mask[b] = on_ms_tick(b);
        end
        return mask;
    endfunction

    always @(posedge i_clk) begin : watch
        logic [LEVEL_W-1:0] want;
        if (!i_rst_n) begin
            clear_state();
            fired_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                apply_trigger_reg(i_cfg_index, i_cfg_data);
            if (i_out_valid && i_out_ready) begin
                if (fired_due.size() == 0) begin
                    $error("fired: no result expected, actual %0h", i_out_data[LEVEL_W-1:0]);
                    mismatch_total++;
                end else begin
                    want = fired_due.pop_front();
                    if (i_out_data[LEVEL_W-1:0] !== want) begin
                        $error("fired: expected %0h, actual %0h", want,
                               i_out_data[LEVEL_W-1:0]);
                        mismatch_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                fired_due.push_back(predict_fired(i_in_user, i_in_data[LEVEL_W-1:0]));
            if (i_eot && !eot_seen) begin
                eot_seen = 1'b1;
                if (fired_due.size() != 0) begin
                    $error("fired: %0d expected results never arrived", fired_due.size());
                    mismatch_total += fired_due.size();
                end
            end
        end
        o_outstanding = fired_due.size();
        o_fail_count  = mismatch_total;
    end

endmodule

### verif/tb.sv
// Testbench top: clock, reset, stimulus and verdict for the button trigger event detector.
`timescale 1ns / 1ps

module tb;

    import btev_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_IDX_UNUSED = 3'd7;

    localparam int RANDOM_ITEMS  = 1050;
    localparam int RANDOM_PHASES = 10;
    // far above the slowest correct run: sparse ready pattern and sender gaps between bursts
    localparam int CYCLE_LIMIT   = 200000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DATA_W-1:0]    s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [DATA_W-1:0]    m_axis_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    logic                 eot = 1'b0;
    int                   outstanding;
    int                   fail_count;
    int                   cycle_count = 0;

    // Mode last written per button, so that a phase can change the times alone
    t_mode                cur_mode [NUM_BUTTONS];
    int                   burst_left = 0;

    // 8 ns period
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    button_trigger_event_fsm dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    btev_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_in_user     (s_axis_tuser),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_eot         (eot),
        .o_outstanding (outstanding),
        .o_fail_count  (fail_count)
    );

    // Stop a hung run: no result may take this long
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver back-pressure: rotate a 16-bit ready pattern and pick a fresh one
    // each time rdy_age wraps, sometimes all ones for a stall-free stretch, sometimes a
    // single bit for a long stall. A random pick has bit 0 forced, so no pattern is all zeros.
    logic [15:0] rdy_pattern = 16'hFFFF;
    int          rdy_age = 0;

    always @(negedge i_clk) begin
        m_axis_tready <= rdy_pattern[0];
        if (rdy_age == 63) begin
            rdy_age <= 0;
            case ($urandom_range(0, 3))
                0:       rdy_pattern <= 16'hFFFF;
                1:       rdy_pattern <= 16'h0001 << $urandom_range(0, 15);
                default: rdy_pattern <= 16'($urandom) | 16'h0001;
            endcase
        end else begin
            rdy_age     <= rdy_age + 1;
            rdy_pattern <= {rdy_pattern[0], rdy_pattern[15:1]};
        end
    end

    function automatic logic [CFG_W-1:0] trig_word(t_mode m, logic [TIME_W-1:0] ms);
        return {m, ms};
    endfunction

    // Present one register write and hold it until the transfer; leave valid high
    // so back-to-back writes need no gap.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        if (idx < NUM_BUTTONS) cur_mode[idx] = t_mode'(val[CFG_W-1:TIME_W]);
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Send one item. Items go out in bursts of random length; between bursts
    // drop valid for a random gap, often none at all.
    task automatic send_item(logic op, logic [LEVEL_W-1:0] lv);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, lv};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Close the stream and hold until every expected mask has come back.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    initial begin
        int                 pick;
        t_mode              m;
        logic [TIME_W-1:0]  ms;
        logic [LEVEL_W-1:0] lv;

        for (int b = 0; b < NUM_BUTTONS; b++) cur_mode[b] = MODE_UNKNOWN;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: one behaviour per button
        write_reg(0, trig_word(MODE_CHANGE, 16'd0));
        write_reg(1, trig_word(MODE_HOLD, 16'd0));       // fires on the press itself
        write_reg(2, trig_word(MODE_HOLD, 16'd2));
        write_reg(3, trig_word(MODE_RELEASE, 16'd0));    // ready at once
        write_reg(4, trig_word(MODE_RELEASE, 16'd2));
        write_reg(5, trig_word(MODE_UNKNOWN, 16'hFFFF)); // edges only reset it
        write_reg(6, trig_word(MODE_HOLD, 16'hFFFF));    // never expires here
        write_reg(REG_IDX_UNUSED, '1);                   // out-of-range index is dropped
        end_writes();

        send_item(OP_SAMPLE, 7'h7F);    // press all
        send_item(OP_TICK, 7'h00);      // levels ignored on a tick
        send_item(OP_TICK, 7'h7F);      // hold wait expires, release becomes ready
        send_item(OP_SAMPLE, 7'h7F);    // no change, nothing fires
        send_item(OP_SAMPLE, 7'h00);    // release all
        send_item(OP_SAMPLE, 7'h14);
        send_item(OP_TICK, 7'h2A);
        send_item(OP_SAMPLE, 7'h00);    // release too early: no event
        send_item(OP_SAMPLE, 7'h10);
        send_item(OP_SAMPLE, 7'h00);
        send_item(OP_SAMPLE, 7'h05);    // button 2 enters a hold wait
        drain();

        // Change the time alone on a running wait, and the mode of a held button
        write_reg(2, trig_word(MODE_HOLD, 16'd5));
        write_reg(0, trig_word(MODE_RELEASE, 16'd0));
        end_writes();
        send_item(OP_TICK, 7'h55);
        send_item(OP_TICK, 7'h00);      // the old countdown still runs out here
        send_item(OP_SAMPLE, 7'h00);    // release of button 0 while idle
        send_item(OP_SAMPLE, 7'h04);    // new press picks up the new time
        repeat (5) send_item(OP_TICK, 7'h7F);
        send_item(OP_SAMPLE, 7'h00);
        drain();

        // Random part: short trigger times so that waits expire often, level
        // changes of one or two buttons at a time, and now and then a wild sample.
        lv = '0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                // every fourth phase changes the times alone
                m    = (ph % 4 == 3) ? cur_mode[b] : t_mode'($urandom_range(0, 3));
                pick = $urandom_range(0, 19);
                if (pick < 4)        ms = '0;
                else if (pick < 7)   ms = 16'd1;
                else if (pick < 16)  ms = TIME_W'($urandom_range(2, 6));
                else if (pick < 18)  ms = 16'hFFFF;
                else                 ms = TIME_W'($urandom);
                if (ph == RANDOM_PHASES - 1 && b % 2 == 0)
                    write_reg(CFG_IDX_W'(b), '1);
                else
                    write_reg(CFG_IDX_W'(b), trig_word(m, ms));
            end
            write_reg(REG_IDX_UNUSED, CFG_W'($urandom));
            end_writes();

            for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_item(OP_TICK, LEVEL_W'($urandom));
                end else begin
                    case ($urandom_range(0, 9))
                        0:       lv = LEVEL_W'($urandom);
                        1:       lv = ~lv;
                        2:       ;
                        3:       lv ^= (LEVEL_W'(1) << $urandom_range(0, 6))
                                     | (LEVEL_W'(1) << $urandom_range(0, 6));
                        default: lv ^= LEVEL_W'(1) << $urandom_range(0, 6);
                    endcase
                    send_item(OP_SAMPLE, lv);
                end
            end
            drain();
        end

        // Count whatever is still outstanding, then give the verdict
        @(negedge i_clk);
        eot <= 1'b1;
        repeat (2) @(negedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/btev_pkg.sv
sv/btev_cell.sv
sv/button_trigger_event_fsm.sv
sv/btev_checker.sv
verif/btev_checker.sv
verif/tb.sv
